// ----- hdl/glpf_pkg.sv -----
`default_nettype none

package glpf_pkg;

  // Line buffer depth and the column index width that follows from it.
  localparam int MAX_COLS = 32;
  localparam int COL_W    = $clog2(MAX_COLS);

  // Field and register widths fixed by the interface.
  localparam int SAMPLE_W   = 16;
  localparam int ROW_W      = 16;
  localparam int CFG_COLS_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 2'd0,
    REG_GRID_COLS = 2'd1
  } cfg_reg_e;

endpackage

`default_nettype wire

// ----- hdl/grid_local_peak_finder_core.sv -----
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ------------------------------------
// cfg       in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// in        in         in_valid_i / in_ready_o    sample_i
// out       out        out_valid_o / out_ready_i  peak_row_o, peak_col_o, run_last_o
//
// One sample per cycle is accepted while the decision stage is free or retiring;
// the line buffer is read at accept and candidates are decided in the cycle after;
// a result then passes the output register. A sample deciding k positions holds
// the decision stage until the output register, moving one transaction per cycle
// while not stalled, has taken all k. Reset clears the counters and handshake
// state; the line buffers need no clearing. A stalled output holds its transaction,
// and input keeps flowing until a sample with a result waits in the decision stage.

`default_nettype none

module grid_local_peak_finder_core import glpf_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic [SAMPLE_W-1:0]   sample_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [ROW_W-1:0]      peak_row_o,
  output      logic [COL_W-1:0]      peak_col_o,
  output      logic                  run_last_o
);

  // Configuration and raster position.
  logic [ROW_W-1:0]      grid_rows_q;
  logic [CFG_COLS_W-1:0] grid_cols_q;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [COL_W-1:0]      col_q, col_d;
  logic                  cfg_write;
  logic                  cfg_restart;

  logic [ROW_W-1:0]      rows_eff;
  logic [CFG_COLS_W-1:0] cols_eff;
  logic [CFG_COLS_W-1:0] col_next_ext;
  logic                  a_last_row;
  logic                  a_has_right;
  logic [COL_W-1:0]      col_right;
  logic                  in_accept;

  // Line buffers.
  sample_t prev_mem  [MAX_COLS];
  sample_t older_mem [MAX_COLS];
  sample_t prev_here_q;
  sample_t prev_right_q;
  sample_t older_rd_q;
  sample_t fwd_data_q;
  logic    fwd_q;

  // Decision stage.
  logic             b_valid_q;
  sample_t          b_sample_q;
  logic [ROW_W-1:0] b_row_q;
  logic [COL_W-1:0] b_col_q;
  logic             b_last_row_q;
  logic             b_has_right_q;
  logic             b_row_ge1_q;
  logic             b_row_ge2_q;
  logic             b_col_ge1_q;
  logic             b_col_ge2_q;
  logic [2:0]       done_q;
  logic [2:0]       cand;
  logic [2:0]       pending;
  logic [2:0]       pick;
  logic [2:0]       rest;
  logic             b_retire;
  logic             out_free;
  logic             out_load;
  sample_t          older_here;

  // Samples to the left: current row at c-1 and c-2, row above at c-1.
  sample_t left_cur_q;
  sample_t left_cur2_q;
  sample_t left_up_q;

  // Output register.
  logic             out_valid_q;
  logic [ROW_W-1:0] out_row_q, out_row_d;
  logic [COL_W-1:0] out_col_q, out_col_d;
  logic             out_last_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;
  assign cfg_restart = cfg_write
                     & ((cfg_index_i == REG_GRID_ROWS) | (cfg_index_i == REG_GRID_COLS));

  assign rows_eff = (grid_rows_q == '0) ? ROW_W'(1) : grid_rows_q;
  always_comb begin
    if (grid_cols_q == '0) begin
      cols_eff = CFG_COLS_W'(1);
    end else if (grid_cols_q > CFG_COLS_W'(MAX_COLS)) begin
      cols_eff = CFG_COLS_W'(MAX_COLS);
    end else begin
      cols_eff = grid_cols_q;
    end
  end

  assign col_next_ext = CFG_COLS_W'(col_q) + CFG_COLS_W'(1);
  assign a_has_right  = col_next_ext < cols_eff;
  assign a_last_row   = row_q == (rows_eff - ROW_W'(1));
  assign col_right    = col_next_ext[COL_W-1:0];

  assign in_ready_o = ~b_valid_q | b_retire;
  assign in_accept  = in_valid_i & in_ready_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_accept) begin
      if (a_has_right) begin
        col_d = col_right;
      end else begin
        col_d = '0;
        row_d = a_last_row ? '0 : row_q + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= ROW_W'(1);
      grid_cols_q <= CFG_COLS_W'(1);
      row_q       <= '0;
      col_q       <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index_i)
          REG_GRID_ROWS: begin
            grid_rows_q <= cfg_data_i[ROW_W-1:0];
          end
          REG_GRID_COLS: begin
            grid_cols_q <= cfg_data_i[CFG_COLS_W-1:0];
          end
          default: begin
          end
        endcase
      end
      // Writing either register restarts the frame.
      if (cfg_restart) begin
        row_q <= '0;
        col_q <= '0;
      end else begin
        row_q <= row_d;
        col_q <= col_d;
      end
    end
  end

  // The previous-row buffer is written at accept, so later reads always see
  // it. The older-row buffer is written when the decision stage retires, which
  // can coincide with a read of the same column in a one-column grid.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      prev_mem[col_q] <= sample_i;
      prev_here_q     <= prev_mem[col_q];
      prev_right_q    <= prev_mem[col_right];
      older_rd_q      <= older_mem[col_q];
      fwd_data_q      <= prev_here_q;
    end
    if (b_retire) begin
      older_mem[b_col_q] <= prev_here_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_accept) begin
      fwd_q <= b_retire & (b_col_q == col_q);
    end
  end

  assign older_here = fwd_q ? fwd_data_q : older_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      b_sample_q    <= sample_i;
      b_row_q       <= row_q;
      b_col_q       <= col_q;
      b_last_row_q  <= a_last_row;
      b_has_right_q <= a_has_right;
      b_row_ge1_q   <= row_q != '0;
      b_row_ge2_q   <= row_q > ROW_W'(1);
      b_col_ge1_q   <= col_q != '0;
      b_col_ge2_q   <= col_q > COL_W'(1);
    end
  end

  // Candidate 0 is the position above, candidate 1 the one to the left in the
  // last row, candidate 2 the sample itself at the end of the frame.
  always_comb begin
    cand[0] = b_row_ge1_q
            & (~b_row_ge2_q | (prev_here_q >= older_here))
            & (~b_col_ge1_q | (prev_here_q >= left_up_q))
            & (~b_has_right_q | (prev_here_q >= prev_right_q))
            & (prev_here_q >= b_sample_q);
    cand[1] = b_last_row_q & b_col_ge1_q
            & (~b_row_ge1_q | (left_cur_q >= left_up_q))
            & (~b_col_ge2_q | (left_cur_q >= left_cur2_q))
            & (left_cur_q >= b_sample_q);
    cand[2] = b_last_row_q & ~b_has_right_q
            & (~b_row_ge1_q | (b_sample_q >= prev_here_q))
            & (~b_col_ge1_q | (b_sample_q >= left_cur_q));
  end

  assign pending = b_valid_q ? (cand & ~done_q) : 3'b000;

  always_comb begin
    pick      = 3'b000;
    out_row_d = b_row_q;
    out_col_d = b_col_q;
    if (pending[0]) begin
      pick      = 3'b001;
      out_row_d = b_row_q - ROW_W'(1);
    end else if (pending[1]) begin
      pick      = 3'b010;
      out_col_d = b_col_q - COL_W'(1);
    end else if (pending[2]) begin
      pick      = 3'b100;
    end
  end

  assign rest     = pending & ~pick;
  assign out_free = ~out_valid_q | out_ready_i;
  assign out_load = (pending != 3'b000) & out_free;
  assign b_retire = b_valid_q & ((pending == 3'b000) | (out_free & (rest == 3'b000)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      done_q    <= '0;
    end else begin
      if (in_accept) begin
        b_valid_q <= 1'b1;
      end else if (b_retire) begin
        b_valid_q <= 1'b0;
      end
      if (b_retire) begin
        done_q <= '0;
      end else if (out_load) begin
        done_q <= done_q | pick;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_cur_q  <= '0;
      left_cur2_q <= '0;
      left_up_q   <= '0;
    end else if (cfg_restart) begin
      left_cur_q  <= '0;
      left_cur2_q <= '0;
      left_up_q   <= '0;
    end else if (b_retire) begin
      left_cur_q  <= b_sample_q;
      left_cur2_q <= left_cur_q;
      left_up_q   <= prev_here_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      out_last_q <= rest == 3'b000;
    end
  end

  assign out_valid_o = out_valid_q;
  assign peak_row_o  = out_row_q;
  assign peak_col_o  = out_col_q;
  assign run_last_o  = out_last_q;

endmodule

`default_nettype wire

// ----- hdl/glpf_checker.sv -----
`default_nettype none

module glpf_checker import glpf_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  cfg_valid_i,
  input wire logic                  cfg_ready_o,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic [ROW_W-1:0]      peak_row_o,
  input wire logic [COL_W-1:0]      peak_col_o,
  input wire logic                  run_last_o
);

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(peak_row_o)
      && $stable(peak_col_o) && $stable(run_last_o))
    else $error("stalled result changed");

  // The input is held off only while a result is on its way out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> out_valid_o)
    else $error("input stalled with no result pending");

  // A result after an empty output comes from the sample that went straight
  // through the decision stage and the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a preceding sample");

  // Configuration is never refused.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind grid_local_peak_finder_core glpf_checker u_glpf_checker (.*);

`default_nettype wire
